FILE: design/nlsc_pkg.sv
// nlsc_pkg: shared constants and types for the length-prefix to start-code converter
// used by nlsc_parser and nal_length_to_start_code_core
`timescale 1ns / 1ps

package nlsc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned PREFIX_IDX_W = 2;

    localparam logic [BYTE_W-1:0] SPS_FIRST_BYTE  = 8'h67;
    localparam logic [BYTE_W-1:0] START_LAST_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] START_ZERO_BYTE = 8'h00;

    localparam logic [PREFIX_IDX_W-1:0] PREFIX_LAST_IDX = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_end;
        logic              sps_present;
    } t_result;

endpackage

FILE: design/nlsc_parser.sv
// nlsc_parser: per-frame state (prefix position, payload count, sps flag) and the
// byte substitution logic; depends on nlsc_pkg
`timescale 1ns / 1ps

module nlsc_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [nlsc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_frame_end,
    output nlsc_pkg::t_result           o_result
);

    logic [nlsc_pkg::PREFIX_IDX_W-1:0] r_prefix_idx, n_prefix_idx;
    logic [3*nlsc_pkg::BYTE_W-1:0]     r_length_acc, n_length_acc;
    logic [nlsc_pkg::COUNT_W-1:0]      r_payload_left, n_payload_left;
    logic                              r_first_pend, n_first_pend;
    logic                              r_sps_found, n_sps_found;

    logic sps_now;
    logic header_done;

    always_comb begin
        sps_now        = r_sps_found
                         | (r_first_pend && (i_data_byte == nlsc_pkg::SPS_FIRST_BYTE));
        header_done    = 1'b0;
        n_prefix_idx   = r_prefix_idx;
        n_length_acc   = r_length_acc;
        n_payload_left = r_payload_left;
        o_result.out_byte = i_data_byte;

        if (r_payload_left != '0) begin
            n_payload_left = r_payload_left - nlsc_pkg::COUNT_W'(1);
        end else if (r_prefix_idx == nlsc_pkg::PREFIX_LAST_IDX) begin
            o_result.out_byte = nlsc_pkg::START_LAST_BYTE;
            header_done       = 1'b1;
            n_payload_left    = {r_length_acc, i_data_byte};
            n_length_acc      = '0;
            n_prefix_idx      = '0;
        end else begin
            o_result.out_byte = nlsc_pkg::START_ZERO_BYTE;
            n_length_acc      = {r_length_acc[2*nlsc_pkg::BYTE_W-1:0], i_data_byte};
            n_prefix_idx      = r_prefix_idx + nlsc_pkg::PREFIX_IDX_W'(1);
        end

        n_first_pend = header_done;
        n_sps_found  = sps_now;

        o_result.out_end     = i_frame_end;
        o_result.sps_present = i_frame_end && sps_now;

        if (i_frame_end) begin
            n_prefix_idx   = '0;
            n_length_acc   = '0;
            n_payload_left = '0;
            n_first_pend   = 1'b0;
            n_sps_found    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_idx   <= '0;
            r_length_acc   <= '0;
            r_payload_left <= '0;
            r_first_pend   <= 1'b0;
            r_sps_found    <= 1'b0;
        end else if (i_advance) begin
            r_prefix_idx   <= n_prefix_idx;
            r_length_acc   <= n_length_acc;
            r_payload_left <= n_payload_left;
            r_first_pend   <= n_first_pend;
            r_sps_found    <= n_sps_found;
        end
    end

`ifndef SYNTHESIS
    // a completed prefix always leaves the first-byte check armed
    a_prefix_arms_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && header_done && !i_frame_end |=> r_first_pend)
        else $error("first byte check not armed after prefix");

    // frame end returns all state to reset
    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_frame_end |=> (r_prefix_idx == '0) && (r_payload_left == '0)
            && !r_sps_found && !r_first_pend)
        else $error("state not cleared at frame end");

    // while payload runs the prefix position stays at its start
    a_payload_no_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_payload_left != '0) |-> (r_prefix_idx == '0) && (r_length_acc == '0))
        else $error("prefix state busy during payload");
`endif

endmodule

FILE: design/nal_length_to_start_code_core.sv
// nal_length_to_start_code_core: top level of the length-prefix to start-code converter
// depends on nlsc_pkg and nlsc_parser
`timescale 1ns / 1ps

// Converts a length-prefixed H.264 frame, one byte per transfer, to start-code form.
// Input channel: i_valid / o_ready with i_data_byte and i_frame_end (last byte).
// Output channel: o_valid / i_ready with o_out_byte, o_out_end and o_sps_present.
// Every input transfer gives exactly one output transfer, in order.
// Each 4-byte big-endian length becomes 00 00 00 01; payload bytes pass unchanged.
// o_sps_present is meaningful with o_out_end: some NAL in the frame began with 0x67.
// Each input byte passes through the input register and then the result register
// on its way to the output channel.
// Throughput: one byte per cycle while i_ready stays high; the per-byte work is a
// 32-bit count-down and a compare between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; o_ready drops only when both are full.
// Reset (i_rst_n low, synchronous) empties both registers and clears the frame state;
// the frame state also clears after every byte marked as frame end.

module nal_length_to_start_code_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [nlsc_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_frame_end,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [nlsc_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_end,
    output logic                        o_sps_present
);

    logic                        r_in_valid;
    logic [nlsc_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_in_end;
    logic                        r_out_valid;
    nlsc_pkg::t_result           r_result;
    nlsc_pkg::t_result           n_result;

    logic advance;
    logic in_take;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    nlsc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_data_byte (r_in_byte),
        .i_frame_end (r_in_end),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_result.out_byte;
    assign o_out_end     = r_result.out_end;
    assign o_sps_present = r_result.sps_present;

`ifndef SYNTHESIS
    // sps flag only on the last byte of a frame
    a_sps_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_end |-> !o_sps_present)
        else $error("sps flag outside frame end");

    // an empty input register never blocks the input channel
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_ready)
        else $error("input stalled with empty input register");

    // a held byte moves on as soon as the result register drains
    a_held_byte_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && i_ready |=> r_out_valid)
        else $error("held byte did not reach the result register");
`endif

endmodule

FILE: bench/nal_length_to_start_code_core_tb.sv
// nal_length_to_start_code_core_tb: self-checking bench for the length-prefix to start-code core
// depends on nlsc_pkg and nal_length_to_start_code_core; predicts every output byte and sps flag
`timescale 1ns / 1ps

module nal_length_to_start_code_core_tb;

    localparam int unsigned PREFIX_LEN   = 4;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned PHASE_ITEMS  = 475;
    localparam int unsigned SETTLE_TICKS = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_ready;
    logic [nlsc_pkg::BYTE_W-1:0] i_data_byte;
    logic                        i_frame_end;
    logic                        o_valid;
    logic                        i_ready;
    logic [nlsc_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_out_end;
    logic                        o_sps_present;

    // converter state mirror
    logic [2:0]                   hdr_idx;
    logic [nlsc_pkg::COUNT_W-1:0] len_acc;
    logic [nlsc_pkg::COUNT_W-1:0] pay_left;
    logic                         first_pending;
    logic                         sps_seen;

    nlsc_pkg::t_result            expected_bytes[$];
    logic [nlsc_pkg::BYTE_W-1:0]  frame_bytes[$];
    int unsigned                  mismatch_count = 0;
    int unsigned                  stuck_cycles = 0;
    int unsigned                  src_idle_pct = 0;
    int unsigned                  sink_stall_pct = 0;

    nal_length_to_start_code_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_frame_end   (i_frame_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_end     (o_out_end),
        .o_sps_present (o_sps_present)
    );

    always #5 i_clk = ~i_clk;

    task automatic clear_frame_state();
        hdr_idx       = '0;
        len_acc       = '0;
        pay_left      = '0;
        first_pending = 1'b0;
        sps_seen      = 1'b0;
    endtask

    task automatic convert_byte(input logic [nlsc_pkg::BYTE_W-1:0] b, input logic e,
                                output nlsc_pkg::t_result r);
        if (first_pending) begin
            if (b == nlsc_pkg::SPS_FIRST_BYTE) begin
                sps_seen = 1'b1;
            end
            first_pending = 1'b0;
        end
        if (pay_left != 0) begin
            r.out_byte = b;
            pay_left   = pay_left - 1;
        end else begin
            r.out_byte = (hdr_idx == 3'(nlsc_pkg::PREFIX_LAST_IDX))
                         ? nlsc_pkg::START_LAST_BYTE : nlsc_pkg::START_ZERO_BYTE;
            len_acc    = {len_acc[nlsc_pkg::COUNT_W-nlsc_pkg::BYTE_W-1:0], b};
            hdr_idx    = hdr_idx + 3'd1;
            if (hdr_idx >= PREFIX_LEN) begin
                pay_left      = len_acc;
                len_acc       = '0;
                hdr_idx       = '0;
                first_pending = 1'b1;
            end
        end
        r.out_end     = e;
        r.sps_present = e && sps_seen;
        if (e) begin
            clear_frame_state();
        end
    endtask

    // predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        nlsc_pkg::t_result exp_r;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                convert_byte(i_data_byte, i_frame_end, exp_r);
                expected_bytes.push_back(exp_r);
            end
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected output transfer: out_byte %0h out_end %0b",
                           o_out_byte, o_out_end);
                    mismatch_count++;
                end else begin
                    exp_r = expected_bytes.pop_front();
                    if (o_out_byte !== exp_r.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", exp_r.out_byte, o_out_byte);
                        mismatch_count++;
                    end
                    if (o_out_end !== exp_r.out_end) begin
                        $error("out_end: expected %0b, got %0b", exp_r.out_end, o_out_end);
                        mismatch_count++;
                    end
                    if (o_sps_present !== exp_r.sps_present) begin
                        $error("sps_present: expected %0b, got %0b",
                               exp_r.sps_present, o_sps_present);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer at all
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_byte(input logic [nlsc_pkg::BYTE_W-1:0] b, input logic e);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_frame_end <= e;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_frame();
        int unsigned n;
        n = frame_bytes.size();
        for (int unsigned k = 0; k < n; k++) begin
            send_byte(frame_bytes[k], k == n - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_length(input logic [nlsc_pkg::COUNT_W-1:0] len);
        frame_bytes.push_back(len[31:24]);
        frame_bytes.push_back(len[23:16]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
    endtask

    task automatic test_sps_frame();
        frame_bytes = {};
        push_length(32'd2);
        frame_bytes.push_back(nlsc_pkg::SPS_FIRST_BYTE);
        frame_bytes.push_back(8'hff);
        send_frame();
    endtask

    // empty nal: the byte after its prefix is compared and then read as a length byte
    task automatic test_zero_length_nal();
        frame_bytes = {};
        push_length(32'd0);
        push_length(32'h6700_0001);
        frame_bytes.push_back(8'h80);
        send_frame();
    endtask

    task automatic test_cut_frames();
        frame_bytes = {8'h00, 8'h00};
        send_frame();
        frame_bytes = {8'hff};
        send_frame();
        frame_bytes = {};
        push_length(32'd5);
        frame_bytes.push_back(8'h66);
        frame_bytes.push_back(8'haa);
        send_frame();
    endtask

    task automatic build_frame();
        int unsigned                  kind;
        int unsigned                  len;
        int unsigned                  body;
        logic [nlsc_pkg::COUNT_W-1:0] hdr;
        frame_bytes = {};
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12);
                hdr = len;
                body = len;
                if ($urandom_range(19) == 0) begin
                    hdr  = $urandom;
                    body = $urandom_range(1, 12);
                end
                push_length(hdr);
                for (int unsigned k = 0; k < body; k++) begin
                    if (k == 0 && $urandom_range(2) == 0) begin
                        frame_bytes.push_back(nlsc_pkg::SPS_FIRST_BYTE);
                    end else begin
                        frame_bytes.push_back(8'($urandom));
                    end
                end
            end
            if (kind < 20) begin
                repeat ($urandom_range(1, 3)) begin
                    if (frame_bytes.size() > 1) begin
                        void'(frame_bytes.pop_back());
                    end
                end
            end
        end
    endtask

    task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned sent;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        while (sent < PHASE_ITEMS) begin
            build_frame();
            send_frame();
            sent += frame_bytes.size();
            if (!paused && sent >= PHASE_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_frame_end = 1'b0;
        i_ready     = 1'b0;
        clear_frame_state();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_sps_frame();
        test_zero_length_nal();
        test_cut_frames();
        test_random_frames(0, 0);
        test_random_frames(51, 0);
        test_random_frames(0, 51);
        test_random_frames(33, 33);

        wait_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
